// File: sv/cfrs_pkg.sv
// ----------------------------------------------------------------------------
// cfrs_pkg
// shared types and constants for the contiguous free-run search unit
// ----------------------------------------------------------------------------
package cfrs_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int BASE_LIMIT     = 256;

	typedef enum logic {
		OP_MARK   = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] slot_index;
		logic       slot_used;
		logic [8:0] request_size;
		logic [7:0] start_index;
	} cfrs_in_t;

	typedef struct packed {
		logic       found;
		logic [7:0] base_index;
	} cfrs_out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic mark_wr;
		logic load;
		logic scan;
		logic res_zero;
		logic res_hit;
	} cfrs_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad_req;
		logic hit;
		logic exhausted;
	} cfrs_status_t;

endpackage

// File: sv/cfrs_datapath.sv
// ----------------------------------------------------------------------------
// cfrs_datapath
// slot map memory, scan address counter, run counter and result register
// ----------------------------------------------------------------------------
module cfrs_datapath
	import cfrs_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfrs_in_t     item,
	input  cfrs_cmd_t    cmd,
	output cfrs_status_t status,
	output cfrs_out_t    result
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int BW = (CW > 9) ? CW : 9;

	logic            map_mem [SLOT_COUNT];
	logic [CW-1:0]   addr_q;
	logic [8:0]      size_q;
	logic [8:0]      run_q;
	logic            vld_s1;
	logic            used_s1;
	logic [CW-1:0]   pos_s1;
	cfrs_out_t       res_q;

	logic [8:0]      eff_size;
	logic            addr_end;
	logic            rd_en;
	logic            hit;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic            wr_data;
	logic [BW-1:0]   base_full;
	logic            found_ok;

	assign eff_size = (item.request_size == 9'd0) ? 9'd1 : item.request_size;
	assign addr_end = (addr_q == CW'(SLOT_COUNT));
	assign rd_en    = cmd.scan && !addr_end;
	assign hit      = vld_s1 && !used_s1 && ((run_q + 9'd1) == size_q);

	assign base_full = BW'(pos_s1) - BW'(run_q);
	assign found_ok  = (base_full < BW'(BASE_LIMIT));

	assign wr_en   = cmd.clr_step ||
		(cmd.mark_wr && (BW'(item.slot_index) < BW'(SLOT_COUNT)));
	assign wr_addr = cmd.clr_step ? addr_q[AW-1:0] : AW'(item.slot_index);
	assign wr_data = cmd.clr_step ? 1'b0 : item.slot_used;

	always_comb begin
		status.clr_last  = (addr_q == CW'(SLOT_COUNT - 1));
		status.bad_req   = (BW'(eff_size) > BW'(SLOT_COUNT)) ||
			(BW'(item.start_index) >= BW'(SLOT_COUNT));
		status.hit       = hit;
		status.exhausted = addr_end && !vld_s1;
	end

	// slot map: 1 = used
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			used_s1 <= map_mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
			res_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				addr_q <= addr_q + CW'(1);
			end else if (cmd.load) begin
				addr_q <= CW'(item.start_index);
			end else if (rd_en) begin
				addr_q <= addr_q + CW'(1);
			end
			vld_s1 <= cmd.load ? 1'b0 : rd_en;
			if (cmd.res_zero) begin
				res_q <= '0;
			end else if (cmd.res_hit) begin
				res_q.found      <= found_ok;
				res_q.base_index <= found_ok ? base_full[7:0] : 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_s1 <= addr_q;
		end
		if (cmd.load) begin
			size_q <= eff_size;
			run_q  <= 9'd0;
		end else if (vld_s1 && !hit) begin
			run_q <= used_s1 ? 9'd0 : (run_q + 9'd1);
		end
	end

	assign result = res_q;

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.hit && status.exhausted))
		else $error("hit and exhausted together");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (run_q < size_q))
		else $error("run counter reached request size without hit");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (BW'(pos_s1) < BW'(SLOT_COUNT)))
		else $error("read beat outside slot map");

endmodule

// File: sv/cfrs_ctrl.sv
// ----------------------------------------------------------------------------
// cfrs_ctrl
// controller: map clear after reset, item accept, scan and result beat
// ----------------------------------------------------------------------------
module cfrs_ctrl
	import cfrs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  op_t          op,
	input  cfrs_status_t status,
	output cfrs_cmd_t    cmd,
	output logic         busy,
	output logic         done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (op == OP_MARK) begin
						cmd.mark_wr  = 1'b1;
						cmd.res_zero = 1'b1;
						state_d      = ST_RESP;
					end else if (status.bad_req) begin
						cmd.res_zero = 1'b1;
						state_d      = ST_RESP;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit) begin
					cmd.res_hit = 1'b1;
					state_d     = ST_RESP;
				end else if (status.exhausted) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	a_resp_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |=> (state_q == ST_IDLE))
		else $error("result beat longer than one cycle");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && status.hit) |=> done)
		else $error("hit did not produce a result beat");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_RESP || state_q == ST_SCAN))
		else $error("accepted item not taken up");

endmodule

// File: sv/contiguous_free_run_search_unit.sv
// ----------------------------------------------------------------------------
// contiguous_free_run_search_unit
// next-fit search for a run of free slots in a slot map, with slot marking
//
//   channel   signals                 beat taken when
//   --------  ----------------------  --------------------------
//   item      start, busy, item       start && !busy at clk edge
//   result    done, result            done high (one cycle)
//
// after reset the slot map is cleared with busy high
// a mark item goes through accept, then the result beat
// a search is accepted, then scans the map upward from start_index, one map
//   read per cycle from a single read port, then gives the result beat
// a result beat cannot be held off; the next item is taken after it
// ----------------------------------------------------------------------------
module contiguous_free_run_search_unit
	import cfrs_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cfrs_in_t  item,
	output logic      busy,
	output logic      done,
	output cfrs_out_t result
);

	cfrs_cmd_t    cmd;
	cfrs_status_t status;

	cfrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cfrs_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
